[hw/rtl/bc1_bc2_bc3_block_decoder_macros.svh]
// Assertion macros for the BC1/BC2/BC3 block decoder checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef BC1_BC2_BC3_BLOCK_DECODER_MACROS_SVH
`define BC1_BC2_BC3_BLOCK_DECODER_MACROS_SVH

// checked only outside reset
`define BCDEC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BCDEC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/bcdec_pkg.sv]
// Shared types, format codes and arithmetic helpers of the BC1/BC2/BC3 decoder.
// No dependencies.
`default_nettype none

package bcdec_pkg;

    // block_format codes (code 3 decodes as BC1)
    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;
    localparam logic [1:0] FMT_BC3 = 2'd2;

    typedef logic [31:0]          t_texel;   // B,G,R,A from bit 0
    typedef logic [3:0][31:0]     t_row;     // texel 0 in the low word
    typedef logic [3:0][3:0][31:0] t_rows;   // row 0 in the low slice
    typedef logic [2:0][7:0]      t_rgb;     // [0]=B, [1]=G, [2]=R

    // (2^n-1 + v*255 + that>>n) >> n for n = 5, 6, 4
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [13:0] t;
        logic [13:0] s;
        t = 14'd31 + ({9'd0, v} << 8) - {9'd0, v};
        s = t + (t >> 5);
        return s[12:5];
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [14:0] t;
        logic [14:0] s;
        t = 15'd63 + ({9'd0, v} << 8) - {9'd0, v};
        s = t + (t >> 6);
        return s[13:6];
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        logic [12:0] t;
        logic [12:0] s;
        t = 13'd15 + ({9'd0, v} << 8) - {9'd0, v};
        s = t + (t >> 4);
        return s[11:4];
    endfunction

    // x/3 for x < 768
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = {10'd0, x} * 20'd683;
        return p[18:11];
    endfunction

    // x/7 for x < 1792
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [21:0] p;
        p = {11'd0, x} * 22'd2341;
        return p[21:14];
    endfunction

    // x/5 for x < 1280
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] p;
        p = {11'd0, x} * 22'd3277;
        return p[21:14];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bc1_bc2_bc3_block_decoder.sv]
// Path: stage 1, stage 2 and stage 3 registers, then the row stage, which drives row 0 first.
// Throughput: one row word per cycle on the output while m_axis_tready is high;
// a block is four row words on the single output channel, which limits the block rate.
// The three front stages take a block every cycle while they have room.
// Reset (i_rst_n low, synchronous): stage valid flags clear, block_format returns to BC1.
// Payload registers are not reset.
`default_nettype none

module bc1_bc2_bc3_block_decoder import bcdec_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // configuration: block_format
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_wdata,
    // input block
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [127:0]   s_axis_tdata,   // [63:0] alpha_block, [127:64] color_block
    // output rows
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [135:0]        m_axis_tdata,   // [1:0] row_index, [33:2] texel_0,
                                                // [65:34] texel_1, [97:66] texel_2,
                                                // [129:98] texel_3, [135:130] zero
    output logic                m_axis_tlast    // last_row
);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [1:0] r_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_BC1;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when the
    // stage after it moves on. Ready ripples back from the row stage.
    // ---------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v;
    logic w_ser_rdy;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3        = !r_s3_v || w_ser_rdy;
    assign w_rdy2        = !r_s2_v || w_rdy3;
    assign w_rdy1        = !r_s1_v || w_rdy2;
    assign s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (w_rdy1) r_s1_v <= s_axis_tvalid;
            if (w_rdy2) r_s2_v <= r_s1_v;
            if (w_rdy3) r_s3_v <= r_s2_v;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: endpoint widening, colour mode decision
    // ---------------------------------------------------------------
    logic [15:0] w_c0, w_c1;
    t_rgb        n_e0, n_e1;
    logic        n_four;
    logic        w_bc1;

    t_rgb        r_s1_e0, r_s1_e1;
    logic        r_s1_four;
    logic [1:0]  r_s1_fmt;
    logic [31:0] r_s1_idx;
    logic [63:0] r_s1_alpha;

    assign w_c0  = s_axis_tdata[79:64];
    assign w_c1  = s_axis_tdata[95:80];
    // format code 3 falls back to BC1
    assign w_bc1 = !(r_fmt == FMT_BC2 || r_fmt == FMT_BC3);

    always_comb begin
        n_e0[0] = widen5(w_c0[4:0]);
        n_e0[1] = widen6(w_c0[10:5]);
        n_e0[2] = widen5(w_c0[15:11]);
        n_e1[0] = widen5(w_c1[4:0]);
        n_e1[1] = widen6(w_c1[10:5]);
        n_e1[2] = widen5(w_c1[15:11]);
        // three-colour + transparent only for BC1 with c0 <= c1
        n_four  = !w_bc1 || (w_c0 > w_c1);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_e0    <= n_e0;
            r_s1_e1    <= n_e1;
            r_s1_four  <= n_four;
            r_s1_fmt   <= r_fmt;
            r_s1_idx   <= s_axis_tdata[127:96];
            r_s1_alpha <= s_axis_tdata[63:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: blend numerators (colour and BC3 alpha)
    // ---------------------------------------------------------------
    logic [2:0][9:0]  n_n2, n_n3;
    t_rgb             n_mean;
    logic [5:0][10:0] n_num7;
    logic [3:0][10:0] n_num5;
    logic [7:0]       w_a0, w_a1;

    t_rgb             r_s2_e0, r_s2_e1, r_s2_mean;
    logic [2:0][9:0]  r_s2_n2, r_s2_n3;
    logic [5:0][10:0] r_s2_num7;
    logic [3:0][10:0] r_s2_num5;
    logic             r_s2_four;
    logic             r_s2_agt;
    logic [1:0]       r_s2_fmt;
    logic [31:0]      r_s2_idx;
    logic [63:0]      r_s2_alpha;

    assign w_a0 = r_s1_alpha[7:0];
    assign w_a1 = r_s1_alpha[15:8];

    always_comb begin
        logic [8:0] sum;
        for (int k = 0; k < 3; k++) begin
            n_n2[k]   = {1'b0, r_s1_e0[k], 1'b0} + {2'b00, r_s1_e1[k]};
            n_n3[k]   = {2'b00, r_s1_e0[k]} + {1'b0, r_s1_e1[k], 1'b0};
            sum       = {1'b0, r_s1_e0[k]} + {1'b0, r_s1_e1[k]};
            n_mean[k] = sum[8:1];
        end
        // seven-step blends: (6-j)*a0 + (j+1)*a1
        for (int j = 0; j < 6; j++) begin
            n_num7[j] = 11'(w_a0) * 11'(6 - j) + 11'(w_a1) * 11'(j + 1);
        end
        // five-step blends: (4-j)*a0 + (j+1)*a1
        for (int j = 0; j < 4; j++) begin
            n_num5[j] = 11'(w_a0) * 11'(4 - j) + 11'(w_a1) * 11'(j + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_e0    <= r_s1_e0;
            r_s2_e1    <= r_s1_e1;
            r_s2_mean  <= n_mean;
            r_s2_n2    <= n_n2;
            r_s2_n3    <= n_n3;
            r_s2_num7  <= n_num7;
            r_s2_num5  <= n_num5;
            r_s2_four  <= r_s1_four;
            r_s2_agt   <= (w_a0 > w_a1);
            r_s2_fmt   <= r_s1_fmt;
            r_s2_idx   <= r_s1_idx;
            r_s2_alpha <= r_s1_alpha;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: palette and alpha table by reciprocal multiply
    // ---------------------------------------------------------------
    logic [3:0][31:0] n_pal;
    logic [7:0][7:0]  n_atab;
    t_rgb             w_m2, w_m3;

    logic [3:0][31:0] r_s3_pal;
    logic [7:0][7:0]  r_s3_atab;
    logic [1:0]       r_s3_fmt;
    logic [31:0]      r_s3_idx;
    logic [63:0]      r_s3_alpha;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_m2[k] = r_s2_four ? div3(r_s2_n2[k]) : r_s2_mean[k];
            w_m3[k] = div3(r_s2_n3[k]);
        end
        n_pal[0] = {8'hff, r_s2_e0};
        n_pal[1] = {8'hff, r_s2_e1};
        n_pal[2] = {8'hff, w_m2};
        // transparent black in three-colour mode
        n_pal[3] = r_s2_four ? {8'hff, w_m3} : 32'd0;

        n_atab[0] = r_s2_alpha[7:0];
        n_atab[1] = r_s2_alpha[15:8];
        for (int j = 0; j < 4; j++) begin
            n_atab[j + 2] = r_s2_agt ? div7(r_s2_num7[j]) : div5(r_s2_num5[j]);
        end
        n_atab[6] = r_s2_agt ? div7(r_s2_num7[4]) : 8'h00;
        n_atab[7] = r_s2_agt ? div7(r_s2_num7[5]) : 8'hff;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_pal   <= n_pal;
            r_s3_atab  <= n_atab;
            r_s3_fmt   <= r_s2_fmt;
            r_s3_idx   <= r_s2_idx;
            r_s3_alpha <= r_s2_alpha;
        end
    end

    // ---------------------------------------------------------------
    // Texel select: palette lookup per texel, alpha by format
    // ---------------------------------------------------------------
    t_rows w_rows;

    always_comb begin
        logic [1:0]  sel;
        logic [31:0] pix;
        logic [7:0]  alpha;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sel = r_s3_idx[2 * (4 * r + c) +: 2];
                pix = r_s3_pal[sel];
                case (r_s3_fmt)
                    FMT_BC2: alpha = widen4(r_s3_alpha[4 * (4 * r + c) +: 4]);
                    FMT_BC3: alpha = r_s3_atab[r_s3_alpha[16 + 3 * (4 * r + c) +: 3]];
                    default: alpha = pix[31:24];
                endcase
                w_rows[r][c] = {alpha, pix[23:0]};
            end
        end
    end

    // ---------------------------------------------------------------
    // Row output stage
    // ---------------------------------------------------------------
    logic [1:0] w_row;
    t_row       w_texels;

    bcdec_row_ser u_row_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s3_v),
        .o_ready  (w_ser_rdy),
        .i_rows   (w_rows),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_row    (w_row),
        .o_texels (w_texels),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_texels, w_row};

endmodule

`default_nettype wire

[hw/rtl/bcdec_row_ser.sv]
// Output stage of the block decoder: holds one decoded block, sends it row by row.
// Depends on bcdec_pkg.
`default_nettype none

module bcdec_row_ser import bcdec_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_rows i_rows,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [1:0] o_row,
    output t_row       o_texels,
    output logic       o_last
);

    logic       r_valid;
    logic [1:0] r_row;
    t_rows      r_rows;
    logic       w_load;
    logic       w_out_acc;

    assign o_last    = (r_row == 2'd3);
    assign w_out_acc = r_valid && i_ready;
    assign o_ready   = !r_valid || (i_ready && o_last);
    assign w_load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_row   <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_row   <= 2'd0;
            end else if (w_out_acc) begin
                r_row <= r_row + 2'd1;
                if (o_last) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    // rows shift down; row 0 slice always drives the port
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rows <= i_rows;
        end else if (w_out_acc) begin
            r_rows[0] <= r_rows[1];
            r_rows[1] <= r_rows[2];
            r_rows[2] <= r_rows[3];
        end
    end

    assign o_valid  = r_valid;
    assign o_row    = r_row;
    assign o_texels = r_rows[0];

endmodule

`default_nettype wire

[hw/rtl/bcdec_checker.sv]
// Port-level checks for the BC1/BC2/BC3 block decoder, bound to the top level.
// Depends on bc1_bc2_bc3_block_decoder_macros.svh.
`default_nettype none
`include "bc1_bc2_bc3_block_decoder_macros.svh"

module bcdec_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [135:0] m_axis_tdata,
    input wire logic         m_axis_tlast
);

    // empty pipeline after reset
    `BCDEC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (s_axis_tready && !m_axis_tvalid), "not empty after reset")

    // tlast marks exactly the fourth row
    `BCDEC_ASSERT_RST(a_last_row, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'd3)), "tlast and row index disagree")

    // rows of a block follow back to back
    `BCDEC_ASSERT_RST(a_row_seq, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && (m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1)), "row sequence broken")

    // stalled word holds
    `BCDEC_ASSERT_RST(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "output changed under stall")

endmodule

bind bc1_bc2_bc3_block_decoder bcdec_checker u_bcdec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
